FILE: src/lbcd_pkg.sv
// ----------------------------------------------------------------------------
// lbcd_pkg
// Shared types and codes of the LRU buffer cache directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbcd_pkg;

  localparam int LBCD_NUM_BUFFERS = 32;
  localparam int LBCD_SLOT_W      = 5;
  localparam int LBCD_COUNT_W     = 8;

  localparam logic [LBCD_COUNT_W-1:0] COUNT_MAX = 8'hFF;

  // commands
  localparam logic [2:0] CMD_GET        = 3'd0;
  localparam logic [2:0] CMD_RELEASE    = 3'd1;
  localparam logic [2:0] CMD_PIN        = 3'd2;
  localparam logic [2:0] CMD_UNPIN      = 3'd3;
  localparam logic [2:0] CMD_MARK_VALID = 3'd4;

  // result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  typedef struct packed {
    logic [2:0]             command;
    logic [7:0]             device;
    logic [31:0]            block_number;
    logic [LBCD_SLOT_W-1:0] slot;
  } lbcd_req_t;

  typedef struct packed {
    logic [LBCD_SLOT_W-1:0]  result_slot;
    logic                    hit;
    logic                    needs_fill;
    logic [LBCD_COUNT_W-1:0] ref_count_out;
    logic [1:0]              status;
  } lbcd_rsp_t;

  // one directory entry: tag and reference count
  typedef struct packed {
    logic [7:0]              device;
    logic [31:0]             block_number;
    logic [LBCD_COUNT_W-1:0] count;
  } lbcd_entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic get_scan;
    logic op_read;
    logic finish;
    logic mtf_scan;
  } lbcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_get;
    logic in_op;
    logic scan_done;
    logic mtf_need;
    logic mtf_done;
    logic rsp_free;
  } lbcd_status_t;

endpackage

FILE: src/lru_buffer_cache_directory.sv
// ----------------------------------------------------------------------------
// lru_buffer_cache_directory
// Buffer cache directory with reference counts and LRU slot recycling.
// ----------------------------------------------------------------------------
// One command is handled at a time. A get walks the recency list from the MRU
// end through a two-deep read pipeline (list memory, then tag memory) and
// stops early on a tag hit. Release, pin and unpin read the slot's tag entry,
// then write back the new count; mark_valid sets its data-valid mark. A release
// that drops a count to zero then walks the list again to move the slot to the
// MRU end, one list entry per cycle, before the next command is taken. The
// result sits in an output register, so the next command is accepted while a
// result waits. Reset needs no clearing pass: per-slot written marks make
// untouched tag entries read zero, an untouched list counts down from the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_buffer_cache_directory
  import lbcd_pkg::*;
#(
  parameter int NUM_BUFFERS = LBCD_NUM_BUFFERS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  lbcd_req_t req_data,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output lbcd_rsp_t rsp_data
);

  lbcd_cmd_t    cmd;
  lbcd_status_t status;

  lbcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lbcd_dpath #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

FILE: src/lbcd_ctrl.sv
// ----------------------------------------------------------------------------
// lbcd_ctrl
// Sequencer of the directory: dispatches one command and steps its scans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbcd_ctrl
  import lbcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  lbcd_status_t status,
  output lbcd_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GSCAN = 3'd1;
  localparam logic [2:0] S_OPRD  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_MTF   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          if (status.in_get) begin
            state_next = S_GSCAN;
          end else if (status.in_op) begin
            state_next = S_OPRD;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_GSCAN: begin
        cmd.get_scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_FIN;
        end
      end
      S_OPRD: begin
        cmd.op_read = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the beat
        if (status.rsp_free) begin
          cmd.finish = 1'b1;
          state_next = status.mtf_need ? S_MTF : S_IDLE;
        end
      end
      S_MTF: begin
        cmd.mtf_scan = 1'b1;
        if (status.mtf_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/lbcd_dpath.sv
// ----------------------------------------------------------------------------
// lbcd_dpath
// Directory storage, recency list walk, count update and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbcd_dpath
  import lbcd_pkg::*;
#(
  parameter int NUM_BUFFERS = LBCD_NUM_BUFFERS
) (
  input  logic         clk,
  input  logic         rst,
  input  lbcd_req_t    req_data,
  input  lbcd_cmd_t    cmd,
  output lbcd_status_t status,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output lbcd_rsp_t    rsp_data
);

  localparam int SW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam logic [SW:0]   NB       = (SW+1)'(NUM_BUFFERS);
  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_BUFFERS - 1);

  // captured request
  lbcd_req_t   req;
  logic        req_get;
  logic        req_op;
  logic [SW-1:0] req_idx;

  // storage
  lbcd_entry_t tag_mem [NUM_BUFFERS];
  logic [SW-1:0] ord_mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] tag_written;
  logic [NUM_BUFFERS-1:0] ord_written;
  logic [NUM_BUFFERS-1:0] data_valid;

  // tag memory ports
  logic        tag_re;
  logic [SW-1:0] tag_ra;
  lbcd_entry_t tag_q;
  logic        tag_wr_q;
  logic [SW-1:0] tag_slot_q;
  lbcd_entry_t tag_eff;
  logic        tag_we;
  logic [SW-1:0] tag_wa;
  lbcd_entry_t tag_wd;

  // order memory ports
  logic        ord_re;
  logic [SW-1:0] ord_q;
  logic        ord_wr_q;
  logic [SW-1:0] ord_pos_q;
  logic [SW-1:0] ord_eff;
  logic        ord_we;

  // walk state
  logic [SW:0] pos_rd;
  logic        ovalid;
  logic        tvalid;
  logic        found;
  logic [SW-1:0] found_slot;
  lbcd_entry_t hit_word;
  logic        free_found;
  logic [SW-1:0] free_slot;
  logic [SW-1:0] carry;
  logic        mtf_done;
  logic        tag_match;

  // finish
  logic        dv_set;
  logic        dv_clr;
  logic [LBCD_COUNT_W-1:0] cnt;
  logic [LBCD_COUNT_W-1:0] newc;
  lbcd_rsp_t   rsp_next;

  assign req_idx = SW'(req.slot);

  // ---------------------------------------------------------------- decode
  always_comb begin
    status.in_get    = (req_data.command == CMD_GET);
    status.in_op     = (req_data.command != CMD_GET) && (req_data.command <= CMD_MARK_VALID)
                       && (32'(req_data.slot) < NUM_BUFFERS);
    status.scan_done = found || ((pos_rd == NB) && !ovalid && !tvalid);
    status.mtf_need  = req_op && (req.command == CMD_RELEASE) && (tag_eff.count == 8'd1);
    status.mtf_done  = mtf_done;
    status.rsp_free  = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req     <= req_data;
      req_get <= status.in_get;
      req_op  <= status.in_op;
    end
  end

  // ---------------------------------------------------------------- memories
  assign ord_re  = (pos_rd < NB) &&
                   ((cmd.get_scan && !found) || (cmd.mtf_scan && !mtf_done));
  assign ord_eff = ord_wr_q ? ord_q : (LAST_IDX - ord_pos_q);
  assign ord_we  = cmd.mtf_scan && ovalid && !mtf_done;

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_pos_q] <= carry;
    end
    if (ord_re) begin
      ord_q     <= ord_mem[pos_rd[SW-1:0]];
      ord_wr_q  <= ord_written[pos_rd[SW-1:0]];
      ord_pos_q <= pos_rd[SW-1:0];
    end
  end

  assign tag_re  = (cmd.get_scan && ovalid) || cmd.op_read;
  assign tag_ra  = cmd.get_scan ? ord_eff : req_idx;
  assign tag_eff = tag_wr_q ? tag_q : '0;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    if (tag_re) begin
      tag_q      <= tag_mem[tag_ra];
      tag_wr_q   <= tag_written[tag_ra];
      tag_slot_q <= tag_ra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_written <= '0;
      ord_written <= '0;
      data_valid  <= '0;
    end else begin
      if (tag_we) begin
        tag_written[tag_wa] <= 1'b1;
      end
      if (ord_we) begin
        ord_written[ord_pos_q] <= 1'b1;
      end
      if (cmd.finish && dv_clr) begin
        data_valid[tag_wa] <= 1'b0;
      end
      if (cmd.finish && dv_set) begin
        data_valid[req_idx] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- walk
  assign tag_match = (tag_eff.device == req.device) &&
                     (tag_eff.block_number == req.block_number);

  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      pos_rd     <= '0;
      ovalid     <= 1'b0;
      tvalid     <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      mtf_done   <= 1'b0;
    end else begin
      if (ord_re) begin
        pos_rd <= pos_rd + 1'b1;
      end
      ovalid <= ord_re;
      tvalid <= cmd.get_scan && ovalid;
      // first tag match from the mru end wins, the last free slot is the lru one
      if (cmd.get_scan && tvalid && !found) begin
        if (tag_match) begin
          found <= 1'b1;
        end else if (tag_eff.count == '0) begin
          free_found <= 1'b1;
        end
      end
      // shift the list down by one until the released slot is reached
      if (ord_we && (ord_eff == req_idx)) begin
        mtf_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      carry <= SW'(req_data.slot);
    end else if (ord_we) begin
      carry <= ord_eff;
    end
    if (cmd.get_scan && tvalid && !found) begin
      if (tag_match) begin
        found_slot <= tag_slot_q;
        hit_word   <= tag_eff;
      end else if (tag_eff.count == '0) begin
        free_slot <= tag_slot_q;
      end
    end
  end

  // ---------------------------------------------------------------- finish
  always_comb begin
    tag_we   = 1'b0;
    tag_wa   = req_idx;
    tag_wd   = tag_eff;
    dv_set   = 1'b0;
    dv_clr   = 1'b0;
    cnt      = tag_eff.count;
    newc     = cnt;
    rsp_next = '{result_slot: req.slot, hit: 1'b0, needs_fill: 1'b0,
                 ref_count_out: '0, status: ST_OK};
    if (req_get) begin
      if (found) begin
        cnt    = hit_word.count;
        newc   = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
        tag_we = 1'b1;
        tag_wa = found_slot;
        tag_wd = '{device: hit_word.device, block_number: hit_word.block_number,
                   count: newc};
        rsp_next = '{result_slot: LBCD_SLOT_W'(found_slot), hit: 1'b1,
                     needs_fill: !data_valid[found_slot], ref_count_out: newc,
                     status: (cnt == COUNT_MAX) ? ST_SAT : ST_OK};
      end else if (free_found) begin
        tag_we = 1'b1;
        tag_wa = free_slot;
        tag_wd = '{device: req.device, block_number: req.block_number, count: 8'd1};
        dv_clr = 1'b1;
        rsp_next = '{result_slot: LBCD_SLOT_W'(free_slot), hit: 1'b0, needs_fill: 1'b1,
                     ref_count_out: 8'd1, status: ST_OK};
      end else begin
        rsp_next = '{result_slot: '0, hit: 1'b0, needs_fill: 1'b0,
                     ref_count_out: '0, status: ST_NOFREE};
      end
    end else if (req_op) begin
      case (req.command)
        CMD_RELEASE, CMD_UNPIN: begin
          if (cnt == '0) begin
            rsp_next.status = ST_ZERO;
          end else begin
            newc   = cnt - 1'b1;
            tag_we = 1'b1;
            tag_wd.count = newc;
            rsp_next.ref_count_out = newc;
          end
        end
        CMD_PIN: begin
          if (cnt == COUNT_MAX) begin
            rsp_next.ref_count_out = cnt;
            rsp_next.status        = ST_SAT;
          end else begin
            newc   = cnt + 1'b1;
            tag_we = 1'b1;
            tag_wd.count = newc;
            rsp_next.ref_count_out = newc;
          end
        end
        CMD_MARK_VALID: begin
          dv_set = 1'b1;
          rsp_next.ref_count_out = cnt;
        end
        default: begin
          rsp_next.ref_count_out = '0;
        end
      endcase
    end
    tag_we = tag_we && cmd.finish;
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

FILE: src/lbcd_chk.sv
// ----------------------------------------------------------------------------
// lbcd_chk
// Port-level checks of the directory, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbcd_chk
  import lbcd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input lbcd_req_t req_data,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input lbcd_rsp_t rsp_data
);

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result beat changed while stalled");

  // one command in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted a beat while busy");

  // no free slot answers all zero
  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == ST_NOFREE) |->
      (rsp_data.result_slot == '0) && !rsp_data.hit && !rsp_data.needs_fill &&
      (rsp_data.ref_count_out == '0))
    else $error("no-free result not cleared");

  // a freshly recycled slot has count one and needs a fill
  a_miss_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.hit && rsp_data.needs_fill |->
      (rsp_data.ref_count_out == 8'd1) && (rsp_data.status == ST_OK))
    else $error("bad miss grant");

  // count-already-zero reports count zero and no hit
  a_zero_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == ST_ZERO) |->
      (rsp_data.ref_count_out == '0) && !rsp_data.hit && !rsp_data.needs_fill)
    else $error("bad zero-count result");

endmodule

bind lru_buffer_cache_directory lbcd_chk u_lbcd_chk (.*);
